// ----- rtl/sopq_pkg.sv -----
package sopq_pkg;

    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int PID_W           = 31;
    localparam int DIST_W          = 31;
    localparam int KIND_W          = 3;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH     = 3'd0,
        KIND_POP      = 3'd1,
        KIND_DRAIN    = 3'd2,
        KIND_CLR_DIST = 3'd3,
        KIND_FIND     = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_TAIL,
        S_RESP
    } state_t;

    typedef struct packed {
        status_t             status;
        logic [PID_W-1:0]    pid;
        logic [DIST_W-1:0]   distance;
        logic                entry_valid;
        logic                found;
        logic                last;
    } res_t;

endpackage

// ----- rtl/sopq_if.sv -----
interface sopq_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [sopq_pkg::KIND_W-1:0]   kind;
    logic [sopq_pkg::PID_W-1:0]    proc_id;
    logic [sopq_pkg::DIST_W-1:0]   stride_distance;

    modport source (output valid, output kind, output proc_id, output stride_distance,
                    input ready);
    modport sink (input valid, input kind, input proc_id, input stride_distance,
                  output ready);
endinterface

interface sopq_res_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    status;
    logic [sopq_pkg::PID_W-1:0]    out_pid;
    logic [sopq_pkg::DIST_W-1:0]   out_distance;
    logic                          entry_valid;
    logic                          found;
    logic                          last;

    modport source (output valid, output status, output out_pid, output out_distance,
                    output entry_valid, output found, output last, input ready);
    modport sink (input valid, input status, input out_pid, input out_distance,
                  input entry_valid, input found, input last, output ready);
endinterface

// ----- rtl/sorted_or_fifo_process_queue.sv -----
// Flow: push in FIFO mode, push to an empty or full queue and all other empty-queue items
//   go straight to the response; pop reads the head; find, distance reset and sorted push
//   scan every entry, one entry read per cycle, and sorted push then writes the tail.
// Throughput: one item at a time; a drain delivers one item per cycle while res is ready.
// Reset: rst_n is asynchronous, active low; the queue comes up empty in sorted mode.
module sorted_or_fifo_process_queue #(
    parameter int QUEUE_DEPTH = sopq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    sopq_cmd_if.sink    cmd,
    sopq_res_if.source  res
);

    localparam int ADDR_W = $clog2(QUEUE_DEPTH);

    logic                          mode_reg;
    logic                          pid_we;
    logic                          dist_we;
    logic [ADDR_W-1:0]             wr_addr;
    logic [sopq_pkg::PID_W-1:0]    wr_pid;
    logic [sopq_pkg::DIST_W-1:0]   wr_dist;
    logic                          rd_en;
    logic [ADDR_W-1:0]             rd_addr;
    logic [sopq_pkg::PID_W-1:0]    rd_pid;
    logic [sopq_pkg::DIST_W-1:0]   rd_dist;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_wdata;
        end
    end

    sopq_ram #(
        .WIDTH (sopq_pkg::PID_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_pid_ram (
        .clk   (clk),
        .we    (pid_we),
        .waddr (wr_addr),
        .wdata (wr_pid),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_pid)
    );

    sopq_ram #(
        .WIDTH (sopq_pkg::DIST_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_dist_ram (
        .clk   (clk),
        .we    (dist_we),
        .waddr (wr_addr),
        .wdata (wr_dist),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_dist)
    );

    sopq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .mode    (mode_reg),
        .cmd     (cmd),
        .res     (res),
        .pid_we  (pid_we),
        .dist_we (dist_we),
        .wr_addr (wr_addr),
        .wr_pid  (wr_pid),
        .wr_dist (wr_dist),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_pid  (rd_pid),
        .rd_dist (rd_dist)
    );

endmodule

// ----- rtl/sopq_ram.sv -----
module sopq_ram #(
    parameter int WIDTH = sopq_pkg::PID_W,
    parameter int DEPTH = sopq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  logic [WIDTH-1:0]           wdata,
    input  logic                       re,
    input  logic [$clog2(DEPTH)-1:0]   raddr,
    output logic [WIDTH-1:0]           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/sopq_ctrl.sv -----
module sopq_ctrl #(
    parameter int QUEUE_DEPTH = sopq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               mode,
    sopq_cmd_if.sink                           cmd,
    sopq_res_if.source                         res,
    output logic                               pid_we,
    output logic                               dist_we,
    output logic [$clog2(QUEUE_DEPTH)-1:0]     wr_addr,
    output logic [sopq_pkg::PID_W-1:0]         wr_pid,
    output logic [sopq_pkg::DIST_W-1:0]        wr_dist,
    output logic                               rd_en,
    output logic [$clog2(QUEUE_DEPTH)-1:0]     rd_addr,
    input  logic [sopq_pkg::PID_W-1:0]         rd_pid,
    input  logic [sopq_pkg::DIST_W-1:0]        rd_dist
);

    localparam int ADDR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

    sopq_pkg::state_t                state_reg, state_next;
    logic [sopq_pkg::KIND_W-1:0]     op_kind_reg, op_kind_next;
    logic [sopq_pkg::PID_W-1:0]      op_pid_reg, op_pid_next;
    logic [sopq_pkg::DIST_W-1:0]     op_dist_reg, op_dist_next;
    logic [CNT_W-1:0]                count_reg, count_next;
    logic [ADDR_W-1:0]               head_reg, head_next;
    logic [CNT_W-1:0]                scan_len_reg, scan_len_next;
    logic [CNT_W-1:0]                rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]                dat_idx_reg, dat_idx_next;
    logic                            dv_reg, dv_next;
    logic [sopq_pkg::PID_W-1:0]      carry_pid_reg, carry_pid_next;
    logic [sopq_pkg::DIST_W-1:0]     carry_dist_reg, carry_dist_next;
    logic                            carrying_reg, carrying_next;
    logic                            hit_reg, hit_next;
    sopq_pkg::res_t                  pend_reg, pend_next;
    sopq_pkg::res_t                  obuf_reg, obuf_next;
    logic                            ovld_reg, ovld_next;
    logic                            out_free;
    logic                            load_out;
    sopq_pkg::res_t                  load_res;
    logic                            consume;
    logic                            scan_done;

    function automatic logic [ADDR_W-1:0] phys(input logic [ADDR_W-1:0] head,
                                               input logic [CNT_W-1:0] idx);
        logic [CNT_W:0] s;
        s = (CNT_W+1)'(head) + (CNT_W+1)'(idx);
        if (s >= (CNT_W+1)'(QUEUE_DEPTH))
        begin
            s = s - (CNT_W+1)'(QUEUE_DEPTH);
        end
        return s[ADDR_W-1:0];
    endfunction

    function automatic sopq_pkg::res_t mk_res(input sopq_pkg::status_t st,
                                             input logic fnd);
        sopq_pkg::res_t r;
        r.status      = st;
        r.pid         = '0;
        r.distance    = '0;
        r.entry_valid = 1'b0;
        r.found       = fnd;
        r.last        = 1'b1;
        return r;
    endfunction

    assign out_free  = !ovld_reg || res.ready;
    assign cmd.ready = (state_reg == sopq_pkg::S_IDLE);

    assign res.valid       = ovld_reg;
    assign res.status      = obuf_reg.status;
    assign res.out_pid     = obuf_reg.pid;
    assign res.out_distance = obuf_reg.distance;
    assign res.entry_valid = obuf_reg.entry_valid;
    assign res.found       = obuf_reg.found;
    assign res.last        = obuf_reg.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= sopq_pkg::S_IDLE;
            count_reg    <= '0;
            head_reg     <= '0;
            scan_len_reg <= '0;
            rd_idx_reg   <= '0;
            dat_idx_reg  <= '0;
            dv_reg       <= 1'b0;
            carrying_reg <= 1'b0;
            hit_reg      <= 1'b0;
            ovld_reg     <= 1'b0;
            op_kind_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            head_reg     <= head_next;
            scan_len_reg <= scan_len_next;
            rd_idx_reg   <= rd_idx_next;
            dat_idx_reg  <= dat_idx_next;
            dv_reg       <= dv_next;
            carrying_reg <= carrying_next;
            hit_reg      <= hit_next;
            ovld_reg     <= ovld_next;
            op_kind_reg  <= op_kind_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_pid_reg     <= op_pid_next;
        op_dist_reg    <= op_dist_next;
        carry_pid_reg  <= carry_pid_next;
        carry_dist_reg <= carry_dist_next;
        pend_reg       <= pend_next;
        obuf_reg       <= obuf_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        op_kind_next    = op_kind_reg;
        op_pid_next     = op_pid_reg;
        op_dist_next    = op_dist_reg;
        count_next      = count_reg;
        head_next       = head_reg;
        scan_len_next   = scan_len_reg;
        rd_idx_next     = rd_idx_reg;
        dat_idx_next    = dat_idx_reg;
        dv_next         = dv_reg;
        carry_pid_next  = carry_pid_reg;
        carry_dist_next = carry_dist_reg;
        carrying_next   = carrying_reg;
        hit_next        = hit_reg;
        pend_next       = pend_reg;
        pid_we          = 1'b0;
        dist_we         = 1'b0;
        wr_addr         = phys(head_reg, dat_idx_reg);
        wr_pid          = op_pid_reg;
        wr_dist         = op_dist_reg;
        rd_en           = 1'b0;
        rd_addr         = phys(head_reg, rd_idx_reg);
        load_out        = 1'b0;
        load_res        = pend_reg;
        consume         = 1'b0;
        scan_done       = (dat_idx_reg == scan_len_reg - CNT_W'(1));

        case (state_reg)
            sopq_pkg::S_IDLE:
            begin
                if (cmd.valid)
                begin
                    op_kind_next  = cmd.kind;
                    op_pid_next   = cmd.proc_id;
                    op_dist_next  = cmd.stride_distance;
                    rd_idx_next   = '0;
                    dv_next       = 1'b0;
                    carrying_next = 1'b0;
                    hit_next      = 1'b0;
                    scan_len_next = count_reg;
                    state_next    = sopq_pkg::S_RESP;
                    pend_next     = mk_res(sopq_pkg::ST_OK, 1'b0);
                    case (cmd.kind)
                        sopq_pkg::KIND_PUSH:
                        begin
                            if (count_reg == CNT_W'(QUEUE_DEPTH))
                            begin
                                pend_next = mk_res(sopq_pkg::ST_FULL, 1'b0);
                            end
                            else if (mode || count_reg == '0)
                            begin
                                pid_we     = 1'b1;
                                dist_we    = 1'b1;
                                wr_addr    = phys(head_reg, count_reg);
                                wr_pid     = cmd.proc_id;
                                wr_dist    = cmd.stride_distance;
                                count_next = count_reg + CNT_W'(1);
                            end
                            else
                            begin
                                state_next = sopq_pkg::S_SCAN;
                            end
                        end
                        sopq_pkg::KIND_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                pend_next = mk_res(sopq_pkg::ST_EMPTY, 1'b0);
                            end
                            else
                            begin
                                scan_len_next = CNT_W'(1);
                                state_next    = sopq_pkg::S_SCAN;
                            end
                        end
                        sopq_pkg::KIND_DRAIN:
                        begin
                            if (count_reg == '0)
                            begin
                                pend_next = mk_res(sopq_pkg::ST_EMPTY, 1'b0);
                            end
                            else
                            begin
                                state_next = sopq_pkg::S_SCAN;
                            end
                        end
                        sopq_pkg::KIND_CLR_DIST, sopq_pkg::KIND_FIND:
                        begin
                            if (count_reg != '0)
                            begin
                                state_next = sopq_pkg::S_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = sopq_pkg::S_RESP;
                        end
                    endcase
                end
            end

            sopq_pkg::S_SCAN:
            begin
                consume = dv_reg && ((op_kind_reg != sopq_pkg::KIND_DRAIN) || out_free);
                rd_en   = (rd_idx_reg < scan_len_reg) && (!dv_reg || consume);
                if (rd_en)
                begin
                    rd_idx_next  = rd_idx_reg + CNT_W'(1);
                    dat_idx_next = rd_idx_reg;
                    dv_next      = 1'b1;
                end
                else if (consume)
                begin
                    dv_next = 1'b0;
                end

                if (consume)
                begin
                    case (op_kind_reg)
                        sopq_pkg::KIND_PUSH:
                        begin
                            // shift the tail up one slot, one entry per cycle
                            if (carrying_reg)
                            begin
                                pid_we          = 1'b1;
                                dist_we         = 1'b1;
                                wr_pid          = carry_pid_reg;
                                wr_dist         = carry_dist_reg;
                                carry_pid_next  = rd_pid;
                                carry_dist_next = rd_dist;
                            end
                            else if (rd_dist > op_dist_reg)
                            begin
                                pid_we          = 1'b1;
                                dist_we         = 1'b1;
                                carry_pid_next  = rd_pid;
                                carry_dist_next = rd_dist;
                                carrying_next   = 1'b1;
                            end
                            if (scan_done)
                            begin
                                state_next = sopq_pkg::S_TAIL;
                            end
                        end
                        sopq_pkg::KIND_POP:
                        begin
                            pend_next.status      = sopq_pkg::ST_OK;
                            pend_next.pid         = rd_pid;
                            pend_next.distance    = rd_dist;
                            pend_next.entry_valid = 1'b1;
                            pend_next.found       = 1'b0;
                            pend_next.last        = 1'b1;
                            head_next             = phys(head_reg, CNT_W'(1));
                            count_next            = count_reg - CNT_W'(1);
                            state_next            = sopq_pkg::S_RESP;
                        end
                        sopq_pkg::KIND_DRAIN:
                        begin
                            load_out             = 1'b1;
                            load_res.status      = sopq_pkg::ST_OK;
                            load_res.pid         = rd_pid;
                            load_res.distance    = rd_dist;
                            load_res.entry_valid = 1'b1;
                            load_res.found       = 1'b0;
                            load_res.last        = scan_done;
                            if (scan_done)
                            begin
                                count_next = '0;
                                state_next = sopq_pkg::S_IDLE;
                            end
                        end
                        sopq_pkg::KIND_CLR_DIST:
                        begin
                            dist_we = 1'b1;
                            wr_dist = '0;
                            if (scan_done)
                            begin
                                pend_next  = mk_res(sopq_pkg::ST_OK, 1'b0);
                                state_next = sopq_pkg::S_RESP;
                            end
                        end
                        sopq_pkg::KIND_FIND:
                        begin
                            hit_next = hit_reg || (rd_pid == op_pid_reg);
                            if (scan_done)
                            begin
                                pend_next  = mk_res(sopq_pkg::ST_OK,
                                                    hit_reg || (rd_pid == op_pid_reg));
                                state_next = sopq_pkg::S_RESP;
                            end
                        end
                        default:
                        begin
                            state_next = sopq_pkg::S_IDLE;
                        end
                    endcase
                end
            end

            sopq_pkg::S_TAIL:
            begin
                pid_we     = 1'b1;
                dist_we    = 1'b1;
                wr_addr    = phys(head_reg, count_reg);
                wr_pid     = carrying_reg ? carry_pid_reg : op_pid_reg;
                wr_dist    = carrying_reg ? carry_dist_reg : op_dist_reg;
                count_next = count_reg + CNT_W'(1);
                pend_next  = mk_res(sopq_pkg::ST_OK, 1'b0);
                state_next = sopq_pkg::S_RESP;
            end

            sopq_pkg::S_RESP:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    load_res   = pend_reg;
                    state_next = sopq_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = sopq_pkg::S_IDLE;
            end
        endcase

        obuf_next = load_out ? load_res : obuf_reg;
        ovld_next = load_out ? 1'b1 : (res.ready ? 1'b0 : ovld_reg);
    end

`ifndef SYNTH
    a_dv_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        dv_reg |-> state_reg == sopq_pkg::S_SCAN)
        else $error("read data pending outside scan");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count beyond depth");

    a_drain_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sopq_pkg::S_SCAN && load_out && load_res.last &&
         op_kind_reg == sopq_pkg::KIND_DRAIN) |=> count_reg == '0)
        else $error("drain left entries behind");

    a_tail_grows: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == sopq_pkg::S_TAIL |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("sorted insert did not grow the queue");
`endif

endmodule

// ----- verif/tb.sv -----
module tb;
    import sopq_pkg::*;

    localparam int DEPTH       = QUEUE_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [PID_W-1:0]  PID_MAX  = {PID_W{1'b1}};
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    typedef struct {
        logic [PID_W-1:0]  pid;
        logic [DIST_W-1:0] distance;
    } slot_t;

    class run_queue_scoreboard;
        slot_t slots[$];
        res_t  pending[$];
        bit    queue_mode;
        int    depth;
        int    mismatches;

        function new(int depth_i);
            depth      = depth_i;
            queue_mode = 1'b0;
            mismatches = 0;
        endfunction

        function void expect_result(status_t st, logic [PID_W-1:0] pid,
                                    logic [DIST_W-1:0] stride, logic ev, logic fnd,
                                    logic lst);
            res_t r;
            r.status      = st;
            r.pid         = pid;
            r.distance    = stride;
            r.entry_valid = ev;
            r.found       = fnd;
            r.last        = lst;
            pending.push_back(r);
        endfunction

        function void note_item(logic [KIND_W-1:0] kind, logic [PID_W-1:0] pid,
                                logic [DIST_W-1:0] stride);
            int    pos;
            slot_t s;
            logic  hit;
            case (kind)
                KIND_PUSH:
                begin
                    if (slots.size() >= depth)
                    begin
                        expect_result(ST_FULL, '0, '0, 1'b0, 1'b0, 1'b1);
                    end
                    else
                    begin
                        pos = slots.size();
                        if (!queue_mode)
                        begin
                            for (int i = 0; i < slots.size(); i++)
                            begin
                                if (slots[i].distance > stride)
                                begin
                                    pos = i;
                                    break;
                                end
                            end
                        end
                        s.pid      = pid;
                        s.distance = stride;
                        slots.insert(pos, s);
                        expect_result(ST_OK, '0, '0, 1'b0, 1'b0, 1'b1);
                    end
                end
                KIND_POP:
                begin
                    if (slots.size() == 0)
                    begin
                        expect_result(ST_EMPTY, '0, '0, 1'b0, 1'b0, 1'b1);
                    end
                    else
                    begin
                        s = slots.pop_front();
                        expect_result(ST_OK, s.pid, s.distance, 1'b1, 1'b0, 1'b1);
                    end
                end
                KIND_DRAIN:
                begin
                    if (slots.size() == 0)
                    begin
                        expect_result(ST_EMPTY, '0, '0, 1'b0, 1'b0, 1'b1);
                    end
                    else
                    begin
                        foreach (slots[i])
                        begin
                            expect_result(ST_OK, slots[i].pid, slots[i].distance, 1'b1,
                                          1'b0, i == slots.size() - 1);
                        end
                        slots.delete();
                    end
                end
                KIND_CLR_DIST:
                begin
                    foreach (slots[i])
                    begin
                        slots[i].distance = '0;
                    end
                    expect_result(ST_OK, '0, '0, 1'b0, 1'b0, 1'b1);
                end
                KIND_FIND:
                begin
                    hit = 1'b0;
                    foreach (slots[i])
                    begin
                        if (slots[i].pid == pid)
                        begin
                            hit = 1'b1;
                        end
                    end
                    expect_result(ST_OK, '0, '0, 1'b0, hit, 1'b1);
                end
                default:
                begin
                    expect_result(ST_OK, '0, '0, 1'b0, 1'b0, 1'b1);
                end
            endcase
        endfunction

        function void report(string what, res_t exp, res_t got);
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("%s: exp st=%0d pid=%h dist=%h ev=%b fnd=%b last=%b",
                         what, exp.status, exp.pid, exp.distance, exp.entry_valid,
                         exp.found, exp.last);
                $display("    got st=%0d pid=%h dist=%h ev=%b fnd=%b last=%b",
                         got.status, got.pid, got.distance, got.entry_valid, got.found,
                         got.last);
            end
        endfunction

        function void check_result(res_t got);
            res_t exp;
            if (pending.size() == 0)
            begin
                report("result with no item pending", '0, got);
            end
            else
            begin
                exp = pending.pop_front();
                if (got.status !== exp.status || got.pid !== exp.pid ||
                    got.distance !== exp.distance || got.entry_valid !== exp.entry_valid ||
                    got.found !== exp.found || got.last !== exp.last)
                begin
                    report("result mismatch", exp, got);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   cycles;

    run_queue_scoreboard board;

    sopq_cmd_if cmd_bus ();
    sopq_res_if res_bus ();

    sorted_or_fifo_process_queue #(
        .QUEUE_DEPTH(DEPTH)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .cmd      (cmd_bus),
        .res      (res_bus)
    );

    always #1 clk = ~clk;

    always @(negedge clk)
    begin
        res_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin : result_monitor
        res_t got;
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            got.status      = status_t'(res_bus.status);
            got.pid         = res_bus.out_pid;
            got.distance    = res_bus.out_distance;
            got.entry_valid = res_bus.entry_valid;
            got.found       = res_bus.found;
            got.last        = res_bus.last;
            board.check_result(got);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** sorted_or_fifo_process_queue: FAILED **");
            $finish;
        end
    end

    function automatic logic [PID_W-1:0] rand_pid();
        case ($urandom_range(3))
            0:       return PID_W'($urandom_range(15));
            1:       return $urandom_range(1) ? PID_MAX : '0;
            default: return PID_W'($urandom);
        endcase
    endfunction

    function automatic logic [DIST_W-1:0] rand_dist();
        case ($urandom_range(3))
            0:       return DIST_W'($urandom_range(7));
            1:       return $urandom_range(1) ? DIST_MAX : '0;
            default: return DIST_W'($urandom);
        endcase
    endfunction

    task automatic submit_op(input logic [KIND_W-1:0] kind, input logic [PID_W-1:0] pid,
                             input logic [DIST_W-1:0] stride);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_bus.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_bus.valid           <= 1'b1;
        cmd_bus.kind            <= kind;
        cmd_bus.proc_id         <= pid;
        cmd_bus.stride_distance <= stride;
        @(posedge clk);
        while (!cmd_bus.ready)
        begin
            @(posedge clk);
        end
        board.note_item(kind, pid, stride);
        @(negedge clk);
    endtask

    task automatic settle_queue(input int pause);
        cmd_bus.valid <= 1'b0;
        while (board.pending.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (pause) @(negedge clk);
    endtask

    task automatic write_queue_mode(input bit mode);
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(negedge clk);
        cfg_we <= 1'b0;
        board.queue_mode = mode;
    endtask

    task automatic run_random_ops(input int n_ops);
        int                done;
        int                fill_at;
        int                r;
        logic [KIND_W-1:0] k;
        logic [PID_W-1:0]  p;
        logic [DIST_W-1:0] d;
        done    = 0;
        fill_at = $urandom_range(n_ops / 4, 3 * n_ops / 4);
        while (done < n_ops)
        begin
            if (done == fill_at)
            begin
                // fill to the brim, then overflow
                while (board.slots.size() < DEPTH)
                begin
                    submit_op(KIND_PUSH, rand_pid(), rand_dist());
                    done++;
                end
                repeat ($urandom_range(1, 2))
                begin
                    submit_op(KIND_PUSH, rand_pid(), rand_dist());
                    done++;
                end
            end
            r = $urandom_range(99);
            p = rand_pid();
            d = rand_dist();
            if (r < 45)
            begin
                k = KIND_PUSH;
            end
            else if (r < 65)
            begin
                k = KIND_POP;
            end
            else if (r < 80)
            begin
                k = KIND_FIND;
                if (board.slots.size() != 0 && $urandom_range(1))
                begin
                    p = board.slots[$urandom_range(board.slots.size() - 1)].pid;
                end
            end
            else if (r < 86)
            begin
                k = KIND_DRAIN;
            end
            else if (r < 94)
            begin
                k = KIND_CLR_DIST;
            end
            else
            begin
                k = KIND_W'($urandom_range(5, 7));
            end
            submit_op(k, p, d);
            if (k <= KIND_FIND)
            begin
                done++;
            end
        end
    endtask

    initial
    begin
        clk                     = 1'b0;
        rst_n                   = 1'b0;
        cfg_we                  = 1'b0;
        cfg_wdata               = 1'b0;
        cmd_bus.valid           = 1'b0;
        cmd_bus.kind            = '0;
        cmd_bus.proc_id         = '0;
        cmd_bus.stride_distance = '0;
        res_bus.ready           = 1'b0;
        cycles                  = 0;
        send_idle_pct           = 13;
        recv_idle_pct           = 70;
        board                   = new(DEPTH);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        write_queue_mode(1'b0);

        // empty queue corners and unused kinds
        submit_op(KIND_POP, rand_pid(), rand_dist());
        submit_op(KIND_DRAIN, rand_pid(), rand_dist());
        submit_op(KIND_CLR_DIST, rand_pid(), rand_dist());
        submit_op(KIND_FIND, '0, rand_dist());
        submit_op(KIND_W'(5), PID_MAX, DIST_MAX);
        submit_op(KIND_W'(6), rand_pid(), rand_dist());
        submit_op(KIND_W'(7), '0, '0);
        // extremes and stable ties
        submit_op(KIND_PUSH, '0, DIST_MAX);
        submit_op(KIND_PUSH, PID_MAX, '0);
        submit_op(KIND_PUSH, PID_W'(5), DIST_W'(7));
        submit_op(KIND_PUSH, PID_W'(6), DIST_W'(7));
        submit_op(KIND_PUSH, PID_W'(7), DIST_W'(3));
        submit_op(KIND_FIND, PID_W'(6), '0);
        submit_op(KIND_FIND, PID_W'(12345), '0);
        submit_op(KIND_POP, '0, '0);
        // switch modes with entries queued
        settle_queue(8);
        write_queue_mode(1'b1);
        submit_op(KIND_PUSH, PID_W'(8), DIST_W'(1));
        submit_op(KIND_PUSH, PID_W'(9), '0);
        settle_queue(8);
        write_queue_mode(1'b0);
        submit_op(KIND_PUSH, PID_W'(10), DIST_W'(5));
        submit_op(KIND_CLR_DIST, '0, '0);
        submit_op(KIND_PUSH, PID_W'(11), '0);
        submit_op(KIND_DRAIN, '0, '0);
        submit_op(KIND_POP, '0, '0);

        run_random_ops(135);

        settle_queue(8);
        send_idle_pct = 70;
        recv_idle_pct = 13;
        write_queue_mode(1'b1);
        run_random_ops(135);

        settle_queue(8);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_queue_mode(1'b0);
        run_random_ops(135);

        settle_queue(DEPTH + 16);
        if (board.mismatches == 0)
        begin
            $display("** sorted_or_fifo_process_queue: PASSED **");
        end
        else
        begin
            $display("** sorted_or_fifo_process_queue: FAILED **");
        end
        $finish;
    end
endmodule
